// ===== rtl/core/etbec_pkg.sv =====
// ----------------------------------------------------------------------------
// Package for the Euler tour balanced edge two-colouring block
// Beat types, opcodes, colour codes and register indexes.
// ----------------------------------------------------------------------------
package etbec_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // Configuration register indexes.
  localparam logic CFG_ROWS_USED = 1'b0;
  localparam logic CFG_COLS_USED = 1'b1;
  localparam int   CFG_W         = 6;

  // Colour codes and result kinds.
  localparam logic [1:0] COLOUR_NONE = 2'd0;
  localparam logic [1:0] COLOUR_ONE  = 2'd1;
  localparam logic [1:0] COLOUR_TWO  = 2'd2;
  localparam logic       KIND_READ   = 1'b0;
  localparam logic       KIND_RUN    = 1'b1;

  // Kind of a vertex held on the walk stack.
  typedef enum logic [1:0] {
    VK_DUMMY = 2'd0,
    VK_ROW   = 2'd1,
    VK_COL   = 2'd2
  } vkind_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] row_index;
    logic [4:0] col_index;
    logic       edge_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cell_colour;
    logic       result_kind;
  } out_item_t;

endpackage

// ===== rtl/core/etbec_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module etbec_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/euler_tour_balanced_edge_two_coloring.sv =====
// ----------------------------------------------------------------------------
// Euler tour balanced edge two-colouring
// A write keeps busy_o high for 1 cycle; a read result is registered from S_RW.
// A run sweeps the table (S_INIT_RD, S_INIT_WR per row and column pair, then
// S_START), walks edges through S_STEP, S_SCAN and S_CLR (dummy links in S_STEP
// alone) and ends each pop in S_POP. One item at a time; results last one cycle
// and cannot be stalled. Reset clears the adjacency via row and column valid flags.
// ----------------------------------------------------------------------------
module euler_tour_balanced_edge_two_coloring
  import etbec_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  in_item_t         in_item_i,
  output logic             result_valid_o,
  output out_item_t        result_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int RAW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IW        = (RAW > CAW) ? RAW : CAW;
  localparam int NI        = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SW        = (NI > 1) ? $clog2(NI) : 1;
  localparam int RCW       = $clog2(MAX_ROWS + 1);
  localparam int CCW       = $clog2(MAX_COLS + 1);
  localparam int STACK_CAP = MAX_ROWS * MAX_COLS + MAX_ROWS + MAX_COLS + 1;
  localparam int DW        = $clog2(STACK_CAP + 1);
  localparam int SAW       = $clog2(STACK_CAP);

  typedef struct packed {
    vkind_e        kind;
    logic [IW-1:0] idx;
  } vtx_t;

  localparam int VW = $bits(vtx_t);

  typedef enum logic [3:0] {
    S_IDLE, S_RW, S_INIT_RD, S_INIT_WR, S_START, S_STEP, S_SCAN, S_CLR, S_POP
  } state_e;

  state_e              state_q, state_d;
  in_item_t            req_q, req_d;
  logic [CFG_W-1:0]    rows_used_q, rows_used_d, cols_used_q, cols_used_d;
  logic [SW-1:0]       sweep_q, sweep_d;
  logic [DW-1:0]       depth_q, depth_d;
  vtx_t                top_q, top_d, prev_q, prev_d;
  logic                prev_vld_q, prev_vld_d;
  logic [IW-1:0]       sel_q, sel_d;
  logic [RAW-1:0]      c2r_q, c2r_d;
  logic [CAW-1:0]      c2c_q, c2c_d;
  logic                c2_pend_q, c2_pend_d;
  logic [MAX_ROWS-1:0] odd_row_q, odd_row_d, dru_q, dru_d, row_nz_q, row_nz_d;
  logic [MAX_COLS-1:0] odd_col_q, odd_col_d, dcu_q, dcu_d;
  logic [MAX_ROWS-1:0] adjr_vld_q, adjr_vld_d, c2_vld_q, c2_vld_d;
  logic [MAX_COLS-1:0] adjc_vld_q, adjc_vld_d;
  logic                adjr_rv_q, adjc_rv_q, c2_rv_q;
  logic                res_vld_q, res_vld_d;
  out_item_t           res_q, res_d;

  // Memory ports.
  logic                adjr_we, adjc_we, avr_we, avc_we, c2_we, stk_we;
  logic [RAW-1:0]      adjr_wa, adjr_ra, avr_wa, avr_ra, c2_wa, c2_ra;
  logic [CAW-1:0]      adjc_wa, adjc_ra, avc_wa, avc_ra;
  logic [MAX_COLS-1:0] adjr_wd, adjr_rd, avr_wd, avr_rd, c2_wd, c2_rd;
  logic [MAX_ROWS-1:0] adjc_wd, adjc_rd, avc_wd, avc_rd;
  logic [SAW-1:0]      stk_wa, stk_ra;
  logic [VW-1:0]       stk_wd, stk_rd;

  // Effective row and column counts and their masks.
  logic [RCW-1:0]      rows_eff;
  logic [CCW-1:0]      cols_eff;
  logic [MAX_COLS-1:0] cmask;
  logic [MAX_ROWS-1:0] rmask;

  always_comb begin
    if (rows_used_q == '0) begin
      rows_eff = RCW'(1);
    end else if (int'(rows_used_q) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_used_q);
    end
    if (cols_used_q == '0) begin
      cols_eff = CCW'(1);
    end else if (int'(cols_used_q) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_used_q);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      cmask[c] = (c < int'(cols_eff));
    end
    for (int r = 0; r < MAX_ROWS; r++) begin
      rmask[r] = (r < int'(rows_eff));
    end
  end

  // Read words with never-written rows and columns seen as zero.
  logic [MAX_COLS-1:0] adjr_word, c2_word;
  logic [MAX_ROWS-1:0] adjc_word;

  assign adjr_word = adjr_rv_q ? adjr_rd : '0;
  assign adjc_word = adjc_rv_q ? adjc_rd : '0;
  assign c2_word   = c2_rv_q ? c2_rd : '0;

  // Priority searches over the availability words and the dummy links.
  logic [CAW-1:0]      avr_hi, dc_hi;
  logic [RAW-1:0]      avc_hi, dr_hi, rs_lo;
  logic                avr_any, avc_any, dc_any, dr_any, rs_any;
  logic [MAX_COLS-1:0] dav_c;
  logic [MAX_ROWS-1:0] dav_r, rs_cand;

  assign dav_c   = odd_col_q & ~dcu_q;
  assign dav_r   = odd_row_q & ~dru_q;
  assign rs_cand = dav_r | row_nz_q;

  always_comb begin
    avr_hi  = '0;
    avr_any = 1'b0;
    dc_hi   = '0;
    dc_any  = 1'b0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (avr_rd[i]) begin
        avr_hi  = CAW'(i);
        avr_any = 1'b1;
      end
      if (dav_c[i]) begin
        dc_hi  = CAW'(i);
        dc_any = 1'b1;
      end
    end
    avc_hi  = '0;
    avc_any = 1'b0;
    dr_hi   = '0;
    dr_any  = 1'b0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (avc_rd[i]) begin
        avc_hi  = RAW'(i);
        avc_any = 1'b1;
      end
      if (dav_r[i]) begin
        dr_hi  = RAW'(i);
        dr_any = 1'b1;
      end
    end
    rs_lo  = '0;
    rs_any = 1'b0;
    for (int i = MAX_ROWS - 1; i >= 0; i--) begin
      if (rs_cand[i]) begin
        rs_lo  = RAW'(i);
        rs_any = 1'b1;
      end
    end
  end

  // Main sequencer: loads, reads, table sweep and the stack walk.
  logic                push_req, pop_req;
  vtx_t                push_v;
  logic [MAX_COLS-1:0] cbit, rw_word, wcol_bit;
  logic [MAX_ROWS-1:0] rbit, cw_word, wrow_bit;
  logic                rin, cin;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rows_used_d = rows_used_q;
    cols_used_d = cols_used_q;
    sweep_d     = sweep_q;
    depth_d     = depth_q;
    top_d       = top_q;
    prev_d      = prev_q;
    prev_vld_d  = prev_vld_q;
    sel_d       = sel_q;
    c2r_d       = c2r_q;
    c2c_d       = c2c_q;
    c2_pend_d   = c2_pend_q;
    odd_row_d   = odd_row_q;
    odd_col_d   = odd_col_q;
    dru_d       = dru_q;
    dcu_d       = dcu_q;
    row_nz_d    = row_nz_q;
    adjr_vld_d  = adjr_vld_q;
    adjc_vld_d  = adjc_vld_q;
    c2_vld_d    = c2_vld_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;
    adjr_we = 1'b0; adjr_wa = '0; adjr_wd = '0; adjr_ra = '0;
    adjc_we = 1'b0; adjc_wa = '0; adjc_wd = '0; adjc_ra = '0;
    avr_we  = 1'b0; avr_wa  = '0; avr_wd  = '0; avr_ra  = '0;
    avc_we  = 1'b0; avc_wa  = '0; avc_wd  = '0; avc_ra  = '0;
    c2_we   = 1'b0; c2_wa   = '0; c2_wd   = '0; c2_ra   = '0;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
    push_req = 1'b0;
    pop_req  = 1'b0;
    push_v   = '0;
    cbit     = MAX_COLS'(1) << CAW'(req_q.col_index);
    rbit     = MAX_ROWS'(1) << RAW'(req_q.row_index);
    wcol_bit = '0;
    wrow_bit = '0;
    rw_word  = '0;
    cw_word  = '0;
    rin      = (int'(req_q.row_index) < int'(rows_eff));
    cin      = (int'(req_q.col_index) < int'(cols_eff));

    // Configuration writes.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_USED: rows_used_d = cfg_wdata_i;
        CFG_COLS_USED: cols_used_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = in_item_i;
          adjr_ra = RAW'(in_item_i.row_index);
          adjc_ra = CAW'(in_item_i.col_index);
          c2_ra   = RAW'(in_item_i.row_index);
          case (in_item_i.opcode)
            OP_WRITE: begin
              if (int'(in_item_i.row_index) < MAX_ROWS &&
                  int'(in_item_i.col_index) < MAX_COLS) begin
                state_d = S_RW;
              end
            end
            OP_READ: state_d = S_RW;
            OP_RUN: begin
              sweep_d = '0;
              dru_d   = '0;
              dcu_d   = '0;
              state_d = S_INIT_RD;
            end
            default: ;
          endcase
        end
      end

      S_RW: begin
        state_d = S_IDLE;
        if (req_q.opcode == OP_WRITE) begin
          adjr_we = 1'b1;
          adjr_wa = RAW'(req_q.row_index);
          adjr_wd = (adjr_word & ~cbit) | (req_q.edge_present ? cbit : '0);
          adjr_vld_d[RAW'(req_q.row_index)] = 1'b1;
          adjc_we = 1'b1;
          adjc_wa = CAW'(req_q.col_index);
          adjc_wd = (adjc_word & ~rbit) | (req_q.edge_present ? rbit : '0);
          adjc_vld_d[CAW'(req_q.col_index)] = 1'b1;
          c2_we = 1'b1;
          c2_wa = RAW'(req_q.row_index);
          c2_wd = c2_word & ~cbit;
          c2_vld_d[RAW'(req_q.row_index)] = 1'b1;
        end else begin
          res_vld_d         = 1'b1;
          res_d.result_kind = KIND_READ;
          if (rin && cin && adjr_word[CAW'(req_q.col_index)]) begin
            res_d.cell_colour = c2_word[CAW'(req_q.col_index)] ? COLOUR_TWO : COLOUR_ONE;
          end else begin
            res_d.cell_colour = COLOUR_NONE;
          end
        end
      end

      // Copy the adjacency into the availability memories, one row and one
      // column each pass, and gather degree parities.
      S_INIT_RD: begin
        adjr_ra = RAW'(sweep_q);
        adjc_ra = CAW'(sweep_q);
        state_d = S_INIT_WR;
      end

      S_INIT_WR: begin
        if (int'(sweep_q) < MAX_ROWS) begin
          rw_word = (int'(sweep_q) < int'(rows_eff)) ? (adjr_word & cmask) : '0;
          avr_we  = 1'b1;
          avr_wa  = RAW'(sweep_q);
          avr_wd  = rw_word;
          row_nz_d[RAW'(sweep_q)]  = |rw_word;
          odd_row_d[RAW'(sweep_q)] = ^rw_word;
          c2_we   = 1'b1;
          c2_wa   = RAW'(sweep_q);
          c2_wd   = '0;
          c2_vld_d[RAW'(sweep_q)] = 1'b1;
        end
        if (int'(sweep_q) < MAX_COLS) begin
          cw_word = (int'(sweep_q) < int'(cols_eff)) ? (adjc_word & rmask) : '0;
          avc_we  = 1'b1;
          avc_wa  = CAW'(sweep_q);
          avc_wd  = cw_word;
          odd_col_d[CAW'(sweep_q)] = ^cw_word;
        end
        if (sweep_q == SW'(NI - 1)) begin
          state_d = S_START;
        end else begin
          sweep_d = sweep_q + SW'(1);
          state_d = S_INIT_RD;
        end
      end

      S_START: begin
        prev_vld_d = 1'b0;
        push_req   = 1'b1;
        if ((|odd_row_q) || (|odd_col_q)) begin
          push_v = vtx_t'{kind: VK_DUMMY, idx: '0};
        end else begin
          push_v = vtx_t'{kind: VK_ROW, idx: '0};
        end
        state_d = S_STEP;
      end

      // Take the dummy link first, otherwise fetch the vertex's word.
      S_STEP: begin
        case (top_q.kind)
          VK_DUMMY: begin
            if (dc_any) begin
              dcu_d[dc_hi] = 1'b1;
              push_req     = 1'b1;
              push_v       = vtx_t'{kind: VK_COL, idx: IW'(dc_hi)};
            end else if (dr_any) begin
              dru_d[dr_hi] = 1'b1;
              push_req     = 1'b1;
              push_v       = vtx_t'{kind: VK_ROW, idx: IW'(dr_hi)};
            end else begin
              pop_req = 1'b1;
            end
          end
          VK_ROW: begin
            if (dav_r[RAW'(top_q.idx)]) begin
              dru_d[RAW'(top_q.idx)] = 1'b1;
              push_req = 1'b1;
              push_v   = vtx_t'{kind: VK_DUMMY, idx: '0};
            end else begin
              avr_ra  = RAW'(top_q.idx);
              state_d = S_SCAN;
            end
          end
          VK_COL: begin
            if (dav_c[CAW'(top_q.idx)]) begin
              dcu_d[CAW'(top_q.idx)] = 1'b1;
              push_req = 1'b1;
              push_v   = vtx_t'{kind: VK_DUMMY, idx: '0};
            end else begin
              avc_ra  = CAW'(top_q.idx);
              state_d = S_SCAN;
            end
          end
          default: pop_req = 1'b1;
        endcase
      end

      // Pick the highest free neighbour and retire the edge on this side.
      S_SCAN: begin
        if (top_q.kind == VK_ROW) begin
          if (avr_any) begin
            wcol_bit = MAX_COLS'(1) << avr_hi;
            avr_we   = 1'b1;
            avr_wa   = RAW'(top_q.idx);
            avr_wd   = avr_rd & ~wcol_bit;
            row_nz_d[RAW'(top_q.idx)] = |(avr_rd & ~wcol_bit);
            avc_ra   = avr_hi;
            sel_d    = IW'(avr_hi);
            state_d  = S_CLR;
          end else begin
            pop_req = 1'b1;
          end
        end else begin
          if (avc_any) begin
            wrow_bit = MAX_ROWS'(1) << avc_hi;
            avc_we   = 1'b1;
            avc_wa   = CAW'(top_q.idx);
            avc_wd   = avc_rd & ~wrow_bit;
            avr_ra   = avc_hi;
            sel_d    = IW'(avc_hi);
            state_d  = S_CLR;
          end else begin
            pop_req = 1'b1;
          end
        end
      end

      // Retire the edge on the far side and step onto the neighbour.
      S_CLR: begin
        push_req = 1'b1;
        state_d  = S_STEP;
        if (top_q.kind == VK_ROW) begin
          wrow_bit = MAX_ROWS'(1) << RAW'(top_q.idx);
          avc_we   = 1'b1;
          avc_wa   = CAW'(sel_q);
          avc_wd   = avc_rd & ~wrow_bit;
          push_v   = vtx_t'{kind: VK_COL, idx: sel_q};
        end else begin
          wcol_bit = MAX_COLS'(1) << CAW'(top_q.idx);
          avr_we   = 1'b1;
          avr_wa   = RAW'(sel_q);
          avr_wd   = avr_rd & ~wcol_bit;
          row_nz_d[RAW'(sel_q)] = |(avr_rd & ~wcol_bit);
          push_v   = vtx_t'{kind: VK_ROW, idx: sel_q};
        end
      end

      // Finish a pop: mark colour two, reload the top or restart the walk.
      S_POP: begin
        if (c2_pend_q) begin
          c2_we = 1'b1;
          c2_wa = c2r_q;
          c2_wd = c2_word | (MAX_COLS'(1) << c2c_q);
        end
        state_d = S_STEP;
        if (depth_q != '0) begin
          top_d = vtx_t'(stk_rd);
        end else if (dc_any || dr_any) begin
          push_req = 1'b1;
          push_v   = vtx_t'{kind: VK_DUMMY, idx: '0};
        end else if (rs_any) begin
          push_req = 1'b1;
          push_v   = vtx_t'{kind: VK_ROW, idx: IW'(rs_lo)};
        end else begin
          res_vld_d         = 1'b1;
          res_d.cell_colour = COLOUR_NONE;
          res_d.result_kind = KIND_RUN;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Stack push; a push onto a full stack is dropped.
    if (push_req && int'(depth_q) < STACK_CAP) begin
      stk_we  = 1'b1;
      stk_wa  = depth_q[SAW-1:0];
      stk_wd  = push_v;
      top_d   = push_v;
      depth_d = depth_q + DW'(1);
    end

    // Stack pop: fetch the new top and start the colour-two update.
    if (pop_req) begin
      depth_d    = depth_q - DW'(1);
      stk_ra     = SAW'(depth_q - DW'(2));
      c2_pend_d  = prev_vld_q && (prev_q.kind == VK_ROW) && (top_q.kind == VK_COL);
      c2r_d      = RAW'(prev_q.idx);
      c2c_d      = CAW'(top_q.idx);
      c2_ra      = RAW'(prev_q.idx);
      prev_d     = top_q;
      prev_vld_d = 1'b1;
      state_d    = S_POP;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_used_q <= CFG_W'(32);
      cols_used_q <= CFG_W'(32);
      sweep_q     <= '0;
      depth_q     <= '0;
      prev_vld_q  <= 1'b0;
      c2_pend_q   <= 1'b0;
      odd_row_q   <= '0;
      odd_col_q   <= '0;
      dru_q       <= '0;
      dcu_q       <= '0;
      row_nz_q    <= '0;
      adjr_vld_q  <= '0;
      adjc_vld_q  <= '0;
      c2_vld_q    <= '0;
      res_vld_q   <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      rows_used_q <= rows_used_d;
      cols_used_q <= cols_used_d;
      sweep_q     <= sweep_d;
      depth_q     <= depth_d;
      prev_vld_q  <= prev_vld_d;
      c2_pend_q   <= c2_pend_d;
      odd_row_q   <= odd_row_d;
      odd_col_q   <= odd_col_d;
      dru_q       <= dru_d;
      dcu_q       <= dcu_d;
      row_nz_q    <= row_nz_d;
      adjr_vld_q  <= adjr_vld_d;
      adjc_vld_q  <= adjc_vld_d;
      c2_vld_q    <= c2_vld_d;
      res_vld_q   <= res_vld_d;
      res_q       <= res_d;
    end
  end

  // Payload registers and read-valid flags that follow the memory reads.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    top_q     <= top_d;
    prev_q    <= prev_d;
    sel_q     <= sel_d;
    c2r_q     <= c2r_d;
    c2c_q     <= c2c_d;
    adjr_rv_q <= adjr_vld_q[adjr_ra];
    adjc_rv_q <= adjc_vld_q[adjc_ra];
    c2_rv_q   <= c2_vld_q[c2_ra];
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // Memories.
  etbec_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS), .AW(RAW)) u_adj_row (
    .clk_i, .we_i(adjr_we), .waddr_i(adjr_wa), .wdata_i(adjr_wd),
    .raddr_i(adjr_ra), .rdata_o(adjr_rd)
  );
  etbec_ram #(.DEPTH(MAX_COLS), .WIDTH(MAX_ROWS), .AW(CAW)) u_adj_col (
    .clk_i, .we_i(adjc_we), .waddr_i(adjc_wa), .wdata_i(adjc_wd),
    .raddr_i(adjc_ra), .rdata_o(adjc_rd)
  );
  etbec_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS), .AW(RAW)) u_avl_row (
    .clk_i, .we_i(avr_we), .waddr_i(avr_wa), .wdata_i(avr_wd),
    .raddr_i(avr_ra), .rdata_o(avr_rd)
  );
  etbec_ram #(.DEPTH(MAX_COLS), .WIDTH(MAX_ROWS), .AW(CAW)) u_avl_col (
    .clk_i, .we_i(avc_we), .waddr_i(avc_wa), .wdata_i(avc_wd),
    .raddr_i(avc_ra), .rdata_o(avc_rd)
  );
  etbec_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS), .AW(RAW)) u_colour_two (
    .clk_i, .we_i(c2_we), .waddr_i(c2_wa), .wdata_i(c2_wd),
    .raddr_i(c2_ra), .rdata_o(c2_rd)
  );
  etbec_ram #(.DEPTH(STACK_CAP), .WIDTH(VW), .AW(SAW)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  // A result only follows a busy cycle, and never two in a row.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o)) else $error("result without work");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");

  // The stack never overruns and is empty between items.
  a_stack_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(depth_q) <= STACK_CAP) else $error("stack overrun");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (depth_q == '0)) else $error("stack not empty when idle");

endmodule

// ===== tb/euler_tour_balanced_edge_two_coloring_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colouring checker for the Euler tour edge two-colouring block
// Watches accepted command beats and configuration writes, keeps its own copy
// of the adjacency matrix and walks the tour itself on each run, then checks
// every result beat against the oldest expected colour in order.
// ----------------------------------------------------------------------------
module euler_tour_balanced_edge_two_coloring_checker
  import etbec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  in_item_t         in_item_i,
  input  logic             result_valid_i,
  input  out_item_t        result_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int NR = 32;
  localparam int NC = 32;
  localparam int NV = NR + NC;

  // Model state.
  bit        adj    [NR][NC];
  bit        used   [NR][NC];
  bit        two    [NR][NC];
  bit        dmy    [NV];
  bit        odd    [NV];
  int        walk_stack[$];
  logic [5:0] rows_reg;
  logic [5:0] cols_reg;

  out_item_t colour_queue[$];
  int        mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = colour_queue.size();

  function automatic int clamp_dim(logic [5:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Next unused edge of vertex u; marks it only when grab is set.
  function automatic int next_neighbour(int u, int nr, int nc, bit grab);
    if (u == 0) begin
      for (int i = nr + nc; i >= 1; i--) begin
        if (odd[i-1] && !dmy[i-1]) begin
          if (grab) dmy[i-1] = 1;
          return i;
        end
      end
      return -1;
    end
    if (u > nr + nc) return -1;
    if (odd[u-1] && !dmy[u-1]) begin
      if (grab) dmy[u-1] = 1;
      return 0;
    end
    if (u <= nr) begin
      for (int i = nc; i >= 1; i--) begin
        if (adj[u-1][i-1] && !used[u-1][i-1]) begin
          if (grab) used[u-1][i-1] = 1;
          return nr + i;
        end
      end
    end else begin
      for (int i = nr; i >= 1; i--) begin
        if (adj[i-1][u-nr-1] && !used[i-1][u-nr-1]) begin
          if (grab) used[i-1][u-nr-1] = 1;
          return i;
        end
      end
    end
    return -1;
  endfunction

  // Hierholzer walk that marks cells crossed from a column to a row.
  task automatic colour_tour();
    int nr, nc, u, nxt, prev;
    bit prev_ok, any_odd;
    nr = clamp_dim(rows_reg, NR);
    nc = clamp_dim(cols_reg, NC);
    prev = 0;
    prev_ok = 0;
    any_odd = 0;
    for (int r = 0; r < NR; r++)
      for (int c = 0; c < NC; c++) begin
        used[r][c] = 0;
        two[r][c]  = 0;
      end
    for (int v = 0; v < NV; v++) begin
      dmy[v] = 0;
      odd[v] = 0;
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (adj[r][c]) begin
          odd[r]      ^= 1;
          odd[nr + c] ^= 1;
        end
    for (int v = 0; v < nr + nc; v++) if (odd[v]) any_odd = 1;
    walk_stack.delete();
    walk_stack.insert(0, any_odd ? 0 : 1);
    while (walk_stack.size() > 0) begin
      u = walk_stack[$];
      nxt = next_neighbour(u, nr, nc, 1);
      if (nxt >= 0) begin
        walk_stack.insert(walk_stack.size(), nxt);
      end else begin
        walk_stack.delete(walk_stack.size() - 1);
        if (prev_ok && prev >= 1 && prev <= nr && u > nr && u <= nr + nc)
          two[prev-1][u-nr-1] = 1;
        prev = u;
        prev_ok = 1;
      end
      if (walk_stack.size() == 0) begin
        for (int v = 0; v <= nr; v++) begin
          if (next_neighbour(v, nr, nc, 0) >= 0) begin
            walk_stack.insert(0, v);
            break;
          end
        end
      end
    end
  endtask

  // Prediction on accepted beats, comparison on result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t expd;
    int nr, nc;
    if (!rst_ni) begin
      for (int r = 0; r < NR; r++)
        for (int c = 0; c < NC; c++) begin
          adj[r][c] = 0;
          two[r][c] = 0;
        end
      rows_reg = 6'd32;
      cols_reg = 6'd32;
      colour_queue.delete();
      mismatches = 0;
    end else begin
      if (result_valid_i) begin
        if (colour_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat colour=%0d kind=%0d", $realtime,
                     result_i.cell_colour, result_i.result_kind);
        end else begin
          expd = colour_queue.pop_front();
          if (result_i.cell_colour !== expd.cell_colour ||
              result_i.result_kind !== expd.result_kind) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch colour exp=%0d got=%0d kind exp=%0d got=%0d",
                       $realtime, expd.cell_colour, result_i.cell_colour,
                       expd.result_kind, result_i.result_kind);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROWS_USED) rows_reg = cfg_wdata_i;
        else cols_reg = cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        case (opcode_e'(in_item_i.opcode))
          OP_WRITE: begin
            adj[in_item_i.row_index][in_item_i.col_index] = in_item_i.edge_present;
            two[in_item_i.row_index][in_item_i.col_index] = 0;
          end
          OP_RUN: begin
            colour_tour();
            want.cell_colour = COLOUR_NONE;
            want.result_kind = KIND_RUN;
            colour_queue.insert(colour_queue.size(), want);
          end
          OP_READ: begin
            nr = clamp_dim(rows_reg, NR);
            nc = clamp_dim(cols_reg, NC);
            want.cell_colour = COLOUR_NONE;
            want.result_kind = KIND_READ;
            if (in_item_i.row_index < nr && in_item_i.col_index < nc &&
                adj[in_item_i.row_index][in_item_i.col_index])
              want.cell_colour = two[in_item_i.row_index][in_item_i.col_index] ?
                                 COLOUR_TWO : COLOUR_ONE;
            colour_queue.insert(colour_queue.size(), want);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/euler_tour_balanced_edge_two_coloring_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Euler tour edge two-colouring block
// Loads small and full adjacency matrices under several row and column
// counts, runs the colouring and reads cells back in random bursts.
// ----------------------------------------------------------------------------
module euler_tour_balanced_edge_two_coloring_test
  import etbec_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         cmd_beat;
  logic             res_valid;
  out_item_t        res_beat;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               cycles;

  euler_tour_balanced_edge_two_coloring u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .in_item_i     (cmd_beat),
    .result_valid_o(res_valid),
    .result_o      (res_beat),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  euler_tour_balanced_edge_two_coloring_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .in_item_i     (cmd_beat),
    .result_valid_i(res_valid),
    .result_i      (res_beat),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock and cycle watchdog.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one command beat and wait until it is taken; start stays high for a
  // following beat and is dropped by the caller before any gap.
  task automatic send_cmd(opcode_e op, logic [4:0] r, logic [4:0] c, logic bitv);
    start          <= 1'b1;
    cmd_beat.opcode       <= op;
    cmd_beat.row_index    <= r;
    cmd_beat.col_index    <= c;
    cmd_beat.edge_present <= bitv;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random gap between bursts.
  task automatic burst_gap();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Registers change only once all results are in and the block is idle.
  task automatic set_dims(logic [CFG_W-1:0] nr, logic [CFG_W-1:0] nc);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ROWS_USED;
    cfg_wdata <= nr;
    @(negedge clk);
    cfg_idx <= CFG_COLS_USED;
    cfg_wdata <= nc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: random writes, reads and runs, mostly in the given area, then a run and reads.
  task automatic phase(int span_r, int span_c, int n_items);
    int burst;
    int k;
    opcode_e op;
    k = 0;
    while (k < n_items) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        case ($urandom_range(0, 19))
          0:       op = OP_NONE;
          1, 2:    op = OP_RUN;
          3, 4, 5, 6, 7, 8: op = OP_READ;
          default: op = OP_WRITE;
        endcase
        if ($urandom_range(0, 9) == 0)
          send_cmd(op, 5'($urandom), 5'($urandom), 1'($urandom));
        else
          send_cmd(op, 5'($urandom_range(0, span_r - 1)),
                   5'($urandom_range(0, span_c - 1)), ($urandom_range(0, 2) != 0));
        k++;
      end
      burst_gap();
    end
    send_cmd(OP_RUN, 5'd0, 5'd0, 1'b0);
    for (int i = 0; i < 6; i++)
      send_cmd(OP_READ, 5'($urandom_range(0, span_r - 1)),
               5'($urandom_range(0, span_c - 1)), 1'b0);
  endtask

  initial begin
    cycles    = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    cmd_beat  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_ROWS_USED;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reads before any run, corners, edges, odd degrees, opcode 3.
    send_cmd(OP_READ, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_cmd(OP_WRITE, 5'd31, 5'd31, 1'b1);
    send_cmd(OP_WRITE, 5'd0, 5'd31, 1'b1);
    send_cmd(OP_WRITE, 5'd31, 5'd0, 1'b1);
    send_cmd(OP_WRITE, 5'd1, 5'd1, 1'b1);
    send_cmd(OP_WRITE, 5'd1, 5'd2, 1'b1);
    send_cmd(OP_READ, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_NONE, 5'd1, 5'd1, 1'b1);
    send_cmd(OP_RUN, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_READ, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_READ, 5'd31, 5'd31, 1'b0);
    send_cmd(OP_READ, 5'd0, 5'd31, 1'b0);
    send_cmd(OP_READ, 5'd31, 5'd0, 1'b0);
    send_cmd(OP_READ, 5'd1, 5'd1, 1'b0);
    send_cmd(OP_READ, 5'd1, 5'd2, 1'b0);
    send_cmd(OP_WRITE, 5'd1, 5'd2, 1'b0);
    send_cmd(OP_READ, 5'd1, 5'd2, 1'b0);
    send_cmd(OP_RUN, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_READ, 5'd1, 5'd1, 1'b0);

    // Zero and oversize counts: reads beyond the used area answer zero.
    set_dims(6'd0, 6'd63);
    send_cmd(OP_RUN, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_READ, 5'd0, 5'd0, 1'b0);
    send_cmd(OP_READ, 5'd1, 5'd1, 1'b0);
    send_cmd(OP_READ, 5'd0, 5'd31, 1'b0);

    // Random phases over several counts.
    set_dims(6'd4, 6'd4);
    phase(4, 4, 15);
    set_dims(6'd3, 6'd5);
    phase(6, 6, 15);
    set_dims(6'd1, 6'd8);
    phase(2, 8, 10);
    set_dims(6'd32, 6'd32);
    phase(32, 32, 20);
    set_dims(6'd33, 6'd1);
    phase(32, 2, 10);

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/etbec_pkg.sv
rtl/core/etbec_ram.sv
rtl/core/euler_tour_balanced_edge_two_coloring.sv
tb/euler_tour_balanced_edge_two_coloring_checker.sv
tb/euler_tour_balanced_edge_two_coloring_test.sv
